// ===== src/utf8wt_pkg.sv =====
// Shared types, constants and helper functions of the UTF-8 word tokenizer.
package utf8wt_pkg;

  // Sizing of the hold buffer, the counters and the command queue.
  localparam int HOLD_DEPTH  = 8;
  localparam int COUNT_WIDTH = 32;
  localparam int QUEUE_DEPTH = 4;

  localparam int HC_W   = $clog2(HOLD_DEPTH + 1);
  localparam int IDX_W  = $clog2(HOLD_DEPTH);
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [HC_W-1:0]   HC_FULL   = HC_W'(HOLD_DEPTH);
  localparam logic [HC_W-1:0]   HC_ONE    = HC_W'(1);
  localparam logic [QPTR_W-1:0] QPTR_ONE  = QPTR_W'(1);
  localparam logic [QPTR_W:0]   QCNT_ONE  = (QPTR_W + 1)'(1);
  localparam logic [QPTR_W:0]   QCNT_FULL = (QPTR_W + 1)'(QUEUE_DEPTH);

  // Result kinds on the output channel.
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_MARK  = 2'd1;
  localparam logic [1:0] KIND_STATS = 2'd2;

  // Bytes of the UTF-8 dashes E2 80 93 / 94 / 95.
  localparam logic [7:0] DASH_LEAD  = 8'hE2;
  localparam logic [7:0] DASH_MID   = 8'h80;
  localparam logic [7:0] DASH_EN    = 8'h93;
  localparam logic [7:0] DASH_EM    = 8'h94;
  localparam logic [7:0] DASH_BAR   = 8'h95;
  localparam logic [1:0] CONT_TAG   = 2'b10;

  // Token phase: outside, no code point yet, one code point, kept.
  typedef enum logic [1:0] {
    PH_OUT,
    PH_NONE,
    PH_ONE,
    PH_KEPT
  } phase_e;

  // Front sequencer: streaming, end-of-text tail, token end, statistics.
  typedef enum logic [1:0] {
    FS_RUN,
    FS_TAIL,
    FS_END,
    FS_STATS
  } fstate_e;

  // Commands from the front to the back.
  typedef enum logic [2:0] {
    OP_STORE,
    OP_OVF,
    OP_EMIT,
    OP_FLUSH,
    OP_MARK,
    OP_STATS
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e         op;
    logic [7:0]      data;
    logic [HC_W-1:0] count;   // Hold index for a store, held length for a flush.
    logic            starts;  // Byte starts a code point.
    logic            last;    // Final result of this command ends the input's run.
  } cmd_t;

  function automatic logic is_boundary(logic [7:0] c);
    logic r;
    r = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D) ||
        (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
        (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
    return r;
  endfunction

  function automatic logic [7:0] lower_ascii(logic [7:0] c);
    logic [7:0] r;
    r = (c >= 8'h41 && c <= 8'h5A) ? (c + 8'h20) : c;
    return r;
  endfunction

  function automatic logic is_dash(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
    logic r;
    r = (b0 == DASH_LEAD) && (b1 == DASH_MID) &&
        ((b2 == DASH_EN) || (b2 == DASH_EM) || (b2 == DASH_BAR));
    return r;
  endfunction

  // Saturating add of a small increment.
  function automatic logic [COUNT_WIDTH-1:0] sat_add(logic [COUNT_WIDTH-1:0] x,
                                                     logic [1:0] k);
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, x} + (COUNT_WIDTH + 1)'(k);
    return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
  endfunction

  // Clip a count to the 32-bit report field.
  function automatic logic [31:0] clip32(logic [COUNT_WIDTH-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

endpackage

// ===== src/utf8wt_front.sv =====
// Front end: lookahead window, dash detection and token classification into commands.
module utf8wt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        text_byte_i,
  input  logic              end_of_text_i,
  input  logic              full_i,
  output logic              push_o,
  output utf8wt_pkg::cmd_t  cmd_o
);

  utf8wt_pkg::fstate_e             state_q, state_d;
  utf8wt_pkg::phase_e              phase_q, phase_d;
  logic [utf8wt_pkg::HC_W-1:0]     hc_q, hc_d;
  logic [7:0]                      la0_q, la0_d, la1_q, la1_d;
  logic [1:0]                      la_cnt_q, la_cnt_d;
  logic [7:0]                      t0_q, t0_d, t1_q, t1_d, t2_q, t2_d;
  logic [1:0]                      tail_cnt_q, tail_cnt_d;

  logic       do_cls, do_end, last, dash, starts;
  logic [7:0] cls_byte, low_byte;

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= utf8wt_pkg::FS_RUN;
      phase_q    <= utf8wt_pkg::PH_OUT;
      hc_q       <= '0;
      la0_q      <= '0;
      la1_q      <= '0;
      la_cnt_q   <= '0;
      t0_q       <= '0;
      t1_q       <= '0;
      t2_q       <= '0;
      tail_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      hc_q       <= hc_d;
      la0_q      <= la0_d;
      la1_q      <= la1_d;
      la_cnt_q   <= la_cnt_d;
      t0_q       <= t0_d;
      t1_q       <= t1_d;
      t2_q       <= t2_d;
      tail_cnt_q <= tail_cnt_d;
    end
  end

  // Next state, window handling and command generation.
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    hc_d       = hc_q;
    la0_d      = la0_q;
    la1_d      = la1_q;
    la_cnt_d   = la_cnt_q;
    t0_d       = t0_q;
    t1_d       = t1_q;
    t2_d       = t2_q;
    tail_cnt_d = tail_cnt_q;
    push_o     = 1'b0;
    cmd_o      = '0;
    do_cls     = 1'b0;
    do_end     = 1'b0;
    last       = 1'b0;
    cls_byte   = 8'h00;
    in_ready_o = (state_q == utf8wt_pkg::FS_RUN) && !full_i;
    dash       = (la_cnt_q == 2'd2) && utf8wt_pkg::is_dash(la0_q, la1_q, text_byte_i);

    unique case (state_q)
      utf8wt_pkg::FS_RUN: begin
        if (in_valid_i && in_ready_o) begin
          if (!end_of_text_i) begin
            last = 1'b1;
            if (la_cnt_q == 2'd2) begin
              if (dash) begin
                do_end   = 1'b1;
                la_cnt_d = 2'd0;
              end else begin
                do_cls   = 1'b1;
                cls_byte = la0_q;
                la0_d    = la1_q;
                la1_d    = text_byte_i;
              end
            end else if (la_cnt_q == 2'd1) begin
              la1_d    = text_byte_i;
              la_cnt_d = 2'd2;
            end else begin
              la0_d    = text_byte_i;
              la_cnt_d = 2'd1;
            end
          end else begin
            // End of text: the window drains through the tail sequence unless a dash closes it.
            la_cnt_d = 2'd0;
            la0_d    = 8'h00;
            la1_d    = 8'h00;
            if (dash) begin
              do_end     = 1'b1;
              tail_cnt_d = 2'd0;
              state_d    = utf8wt_pkg::FS_END;
            end else begin
              state_d = utf8wt_pkg::FS_TAIL;
              if (la_cnt_q == 2'd2) begin
                t0_d       = la0_q;
                t1_d       = la1_q;
                t2_d       = text_byte_i;
                tail_cnt_d = 2'd3;
              end else if (la_cnt_q == 2'd1) begin
                t0_d       = la0_q;
                t1_d       = text_byte_i;
                tail_cnt_d = 2'd2;
              end else begin
                t0_d       = text_byte_i;
                tail_cnt_d = 2'd1;
              end
            end
          end
        end
      end
      utf8wt_pkg::FS_TAIL: begin
        if (!full_i) begin
          do_cls     = 1'b1;
          cls_byte   = t0_q;
          t0_d       = t1_q;
          t1_d       = t2_q;
          tail_cnt_d = tail_cnt_q - 2'd1;
          if (tail_cnt_q == 2'd1) begin
            state_d = utf8wt_pkg::FS_END;
          end
        end
      end
      utf8wt_pkg::FS_END: begin
        if (!full_i) begin
          push_o = 1'b1;
          if (phase_q == utf8wt_pkg::PH_KEPT) begin
            cmd_o.op = utf8wt_pkg::OP_MARK;
            state_d  = utf8wt_pkg::FS_STATS;
          end else begin
            cmd_o.op   = utf8wt_pkg::OP_STATS;
            cmd_o.last = 1'b1;
            state_d    = utf8wt_pkg::FS_RUN;
          end
          phase_d = utf8wt_pkg::PH_OUT;
          hc_d    = '0;
        end
      end
      utf8wt_pkg::FS_STATS: begin
        if (!full_i) begin
          push_o     = 1'b1;
          cmd_o.op   = utf8wt_pkg::OP_STATS;
          cmd_o.last = 1'b1;
          state_d    = utf8wt_pkg::FS_RUN;
        end
      end
      default: begin
        state_d = utf8wt_pkg::FS_RUN;
      end
    endcase

    // Classification of one byte against the token phase.
    starts   = (cls_byte[7:6] != utf8wt_pkg::CONT_TAG);
    low_byte = utf8wt_pkg::lower_ascii(cls_byte);
    if (do_cls && utf8wt_pkg::is_boundary(cls_byte)) begin
      do_end = 1'b1;
    end else if (do_cls) begin
      push_o       = 1'b1;
      cmd_o.data   = low_byte;
      cmd_o.starts = starts;
      cmd_o.last   = last;
      if (phase_q == utf8wt_pkg::PH_KEPT) begin
        cmd_o.op = utf8wt_pkg::OP_EMIT;
      end else if (starts && phase_q == utf8wt_pkg::PH_ONE) begin
        cmd_o.op    = utf8wt_pkg::OP_FLUSH;
        cmd_o.count = hc_q;
        hc_d        = '0;
        phase_d     = utf8wt_pkg::PH_KEPT;
      end else begin
        if (starts) begin
          phase_d = utf8wt_pkg::PH_ONE;
        end else if (phase_q == utf8wt_pkg::PH_OUT) begin
          phase_d = utf8wt_pkg::PH_NONE;
        end
        if (hc_q < utf8wt_pkg::HC_FULL) begin
          cmd_o.op    = utf8wt_pkg::OP_STORE;
          cmd_o.count = hc_q;
          hc_d        = hc_q + utf8wt_pkg::HC_ONE;
        end else begin
          cmd_o.op = utf8wt_pkg::OP_OVF;
        end
      end
    end

    // Token end: only a kept token shows a marker.
    if (do_end) begin
      if (phase_q == utf8wt_pkg::PH_KEPT) begin
        push_o     = 1'b1;
        cmd_o      = '0;
        cmd_o.op   = utf8wt_pkg::OP_MARK;
        cmd_o.last = last;
      end
      phase_d = utf8wt_pkg::PH_OUT;
      hc_d    = '0;
    end
  end

endmodule

// ===== src/utf8wt_cmd_queue.sv =====
// Small command queue that decouples the front end from the back end.
module utf8wt_cmd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  utf8wt_pkg::cmd_t  push_cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output utf8wt_pkg::cmd_t  head_o
);

  utf8wt_pkg::cmd_t              mem_q [utf8wt_pkg::QUEUE_DEPTH];
  logic [utf8wt_pkg::QPTR_W-1:0] wr_q, rd_q;
  logic [utf8wt_pkg::QPTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == utf8wt_pkg::QCNT_FULL);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + utf8wt_pkg::QPTR_ONE;
      end
      if (pop_i) begin
        rd_q <= rd_q + utf8wt_pkg::QPTR_ONE;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + utf8wt_pkg::QCNT_ONE;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - utf8wt_pkg::QCNT_ONE;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== src/utf8wt_back.sv =====
// Back end: hold buffer, word and code point counters and the output register.
module utf8wt_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  utf8wt_pkg::cmd_t  head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        item_kind_o,
  output logic [7:0]        token_byte_o,
  output logic [31:0]       word_count_o,
  output logic [31:0]       char_count_o,
  output logic              hold_overflow_o,
  output logic              last_of_run_o
);

  logic [7:0]                         hold_q [utf8wt_pkg::HOLD_DEPTH];
  logic [utf8wt_pkg::HC_W-1:0]        flush_idx_q, flush_idx_d;
  logic [utf8wt_pkg::COUNT_WIDTH-1:0] words_q, words_d, chars_q, chars_d;
  logic                               ovf_q, ovf_d;
  logic                               out_valid_q;
  logic [1:0]                         kind_q, kind_d;
  logic [7:0]                         byte_q, byte_d;
  logic [31:0]                        wc_q, wc_d, cc_q, cc_d;
  logic                               hov_q, hov_d, last_q, last_d;
  logic                               can_emit, emit, hold_we;

  assign can_emit = !out_valid_q || out_ready_i;

  // Command execution, one result per cycle at most.
  always_comb begin
    pop_o       = 1'b0;
    emit        = 1'b0;
    hold_we     = 1'b0;
    flush_idx_d = flush_idx_q;
    words_d     = words_q;
    chars_d     = chars_q;
    ovf_d       = ovf_q;
    kind_d      = utf8wt_pkg::KIND_BYTE;
    byte_d      = 8'h00;
    wc_d        = 32'h0;
    cc_d        = 32'h0;
    hov_d       = 1'b0;
    last_d      = head_i.last;
    if (!empty_i) begin
      unique case (head_i.op)
        utf8wt_pkg::OP_STORE: begin
          pop_o   = 1'b1;
          hold_we = 1'b1;
        end
        utf8wt_pkg::OP_OVF: begin
          pop_o = 1'b1;
          ovf_d = 1'b1;
        end
        utf8wt_pkg::OP_EMIT: begin
          if (can_emit) begin
            emit   = 1'b1;
            pop_o  = 1'b1;
            byte_d = head_i.data;
            if (head_i.starts) begin
              chars_d = utf8wt_pkg::sat_add(chars_q, 2'd1);
            end
          end
        end
        utf8wt_pkg::OP_FLUSH: begin
          // Held bytes go out first, then the byte that kept the token.
          if (can_emit) begin
            emit = 1'b1;
            if (flush_idx_q < head_i.count) begin
              byte_d      = hold_q[flush_idx_q[utf8wt_pkg::IDX_W-1:0]];
              last_d      = 1'b0;
              flush_idx_d = flush_idx_q + utf8wt_pkg::HC_ONE;
            end else begin
              byte_d      = head_i.data;
              pop_o       = 1'b1;
              flush_idx_d = '0;
              words_d     = utf8wt_pkg::sat_add(words_q, 2'd1);
              chars_d     = utf8wt_pkg::sat_add(chars_q, 2'd2);
            end
          end
        end
        utf8wt_pkg::OP_MARK: begin
          if (can_emit) begin
            emit   = 1'b1;
            pop_o  = 1'b1;
            kind_d = utf8wt_pkg::KIND_MARK;
          end
        end
        utf8wt_pkg::OP_STATS: begin
          if (can_emit) begin
            emit    = 1'b1;
            pop_o   = 1'b1;
            kind_d  = utf8wt_pkg::KIND_STATS;
            wc_d    = utf8wt_pkg::clip32(words_q);
            cc_d    = utf8wt_pkg::clip32(chars_q);
            hov_d   = ovf_q;
            words_d = '0;
            chars_d = '0;
            ovf_d   = 1'b0;
          end
        end
        default: begin
          pop_o = 1'b1;
        end
      endcase
    end
  end

  // Control state and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flush_idx_q <= '0;
      words_q     <= '0;
      chars_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      flush_idx_q <= flush_idx_d;
      words_q     <= words_d;
      chars_q     <= chars_d;
      ovf_q       <= ovf_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold buffer writes.
  always_ff @(posedge clk_i) begin
    if (hold_we) begin
      hold_q[head_i.count[utf8wt_pkg::IDX_W-1:0]] <= head_i.data;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q <= kind_d;
      byte_q <= byte_d;
      wc_q   <= wc_d;
      cc_q   <= cc_d;
      hov_q  <= hov_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign item_kind_o     = kind_q;
  assign token_byte_o    = byte_q;
  assign word_count_o    = wc_q;
  assign char_count_o    = cc_q;
  assign hold_overflow_o = hov_q;
  assign last_of_run_o   = last_q;

endmodule

// ===== src/utf8_word_tokenizer.sv =====
// A result passes through the command queue and the output register; a byte is classified only
// once two more bytes have arrived, as the dash lookahead needs them. Throughput: one byte per
// cycle while the queue has room; a kept token's held bytes leave one per cycle through the
// output register while it is not stalled, as the four-entry queue keeps taking input until
// full, then input stalls. End of text holds input off while the tail classifies each window
// byte (a closing dash skips it), then a kept open token's marker and statistics are queued.
// Reset is asynchronous and clears window, token state, counters, queue, not the hold buffer.
module utf8_word_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  item_kind_o,
  output logic [7:0]  token_byte_o,
  output logic [31:0] word_count_o,
  output logic [31:0] char_count_o,
  output logic        hold_overflow_o,
  output logic        last_of_run_o
);

  logic             push, full, pop, empty;
  utf8wt_pkg::cmd_t push_cmd, head_cmd;

  // Classification front end.
  utf8wt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .text_byte_i  (text_byte_i),
    .end_of_text_i(end_of_text_i),
    .full_i       (full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  // Command queue between the two halves.
  utf8wt_cmd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .full_o    (full),
    .pop_i     (pop),
    .empty_o   (empty),
    .head_o    (head_cmd)
  );

  // Execution back end and output register.
  utf8wt_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .head_i         (head_cmd),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .item_kind_o    (item_kind_o),
    .token_byte_o   (token_byte_o),
    .word_count_o   (word_count_o),
    .char_count_o   (char_count_o),
    .hold_overflow_o(hold_overflow_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

// ===== src/utf8wt_checker.sv =====
// Port-level checker for the tokenizer and its bind to the top level.
module utf8wt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  text_byte_i,
  input logic        end_of_text_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  item_kind_o,
  input logic [7:0]  token_byte_o,
  input logic [31:0] word_count_o,
  input logic [31:0] char_count_o,
  input logic        hold_overflow_o,
  input logic        last_of_run_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(item_kind_o) && $stable(token_byte_o) &&
      $stable(word_count_o) && $stable(char_count_o) && $stable(last_of_run_o))
    else $error("stalled result changed");

  // Only a statistics result carries counts and the overflow flag.
  a_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && item_kind_o != utf8wt_pkg::KIND_STATS |->
      word_count_o == 32'h0 && char_count_o == 32'h0 && !hold_overflow_o)
    else $error("count fields set on a non-statistics result");

  // The statistics result always closes the run of the final byte.
  a_stats_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && item_kind_o == utf8wt_pkg::KIND_STATS |->
      last_of_run_o && token_byte_o == 8'h00)
    else $error("statistics result is not last of its run");

endmodule

bind utf8_word_tokenizer utf8wt_checker u_checker (.*);
